// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker of the sorted list unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sorted list check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SLI_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sorted list check failed");

`endif

// ===== rtl/sli_pkg.sv =====
// Types and codes shared by the sorted list unit, its cells and its checker.
package sli_pkg;

    localparam int unsigned ValueWidth = 32;
    localparam int unsigned CountPortWidth = 5;

    typedef enum logic {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    // Command broadcast to every cell of the chain.
    typedef struct packed {
        logic                          update;
        logic                          is_insert;
        logic signed [ValueWidth-1:0]  value;
    } cell_cmd_t;

endpackage

// ===== rtl/sorted_list_insert_remove_unit.sv =====
// Top level of the descending sorted list: cell chain, count and response register.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------
//  request | req_valid/req_ready  | req_type, value
//  response| rsp_valid/rsp_ready  | status, entry_count
//
// One request per cycle while responses are drained: every cell compares against
// the value and shifts in the same cycle, and the response appears in the next cycle.
// Reset clears the internal count and the response valid; cell contents and the response payload are never cleared.
// A request is taken whenever the response register is empty or being drained,
// so a stalled response holds off the request channel until it is taken.
module sorted_list_insert_remove_unit #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   req_valid,
    output logic                                   req_ready,
    input  logic                                   req_type,
    input  logic signed [sli_pkg::ValueWidth-1:0]  value,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic [1:0]                             status,
    output logic [sli_pkg::CountPortWidth-1:0]     entry_count
);
    import sli_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]                 count_reg;
    logic [CW-1:0]                 count_next;
    logic                          rsp_valid_reg;
    logic                          rsp_valid_next;
    status_t                       status_reg;
    status_t                       status_next;
    logic [CountPortWidth-1:0]     entry_count_reg;
    logic [CountPortWidth-1:0]     entry_count_next;
    logic [CW+CountPortWidth-1:0]  count_ext;

    logic                          accept;
    logic                          is_insert;
    logic                          full;
    logic                          empty;
    logic                          found;
    cell_cmd_t                     cmd;

    logic [CAPACITY-1:0]           gt_vec;
    logic [CAPACITY-1:0]           hit_vec;
    logic signed [ValueWidth-1:0]  entry_vec [CAPACITY];

    assign accept    = req_valid && req_ready;
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign is_insert = (req_type_t'(req_type) == REQ_INSERT);
    assign full      = (count_reg == CW'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign found     = |hit_vec;

    assign cmd.update    = accept && (is_insert ? !full : (!empty && found));
    assign cmd.is_insert = is_insert;
    assign cmd.value     = value;

    // Build the chain of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                         left_gt_w;
        logic signed [ValueWidth-1:0] left_value_w;
        logic signed [ValueWidth-1:0] right_value_w;

        if (i == 0)
        begin : g_head
            assign left_gt_w    = 1'b1;
            assign left_value_w = value;
        end
        else
        begin : g_body
            assign left_gt_w    = gt_vec[i-1];
            assign left_value_w = entry_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_tail
            assign right_value_w = entry_vec[i];
        end
        else
        begin : g_inner
            assign right_value_w = entry_vec[i+1];
        end

        sli_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (CW'(i) < count_reg),
            .left_gt     (left_gt_w),
            .left_value  (left_value_w),
            .right_value (right_value_w),
            .gt          (gt_vec[i]),
            .hit         (hit_vec[i]),
            .entry       (entry_vec[i])
        );
    end

    // Work out status and the new count of a request
    always_comb
    begin
        count_next  = count_reg;
        status_next = status_reg;
        if (accept)
        begin
            if (is_insert)
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_OK;
                    count_next  = count_reg + CW'(1);
                end
            end
            else
            begin
                priority if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (found)
                begin
                    status_next = ST_OK;
                    count_next  = count_reg - CW'(1);
                end
                else
                begin
                    status_next = ST_NOT_FOUND;
                end
            end
        end
    end

    assign count_ext        = {{CountPortWidth{1'b0}}, count_next};
    assign entry_count_next = accept ? count_ext[CountPortWidth-1:0] : entry_count_reg;
    assign rsp_valid_next   = accept || (rsp_valid_reg && !rsp_ready);

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

// ===== rtl/sli_cell.sv =====
// One storage cell of the sorted chain: compares its entry and shifts with its neighbors.
module sli_cell (
    input  logic                                   clk,
    input  sli_pkg::cell_cmd_t                     cmd,
    input  logic                                   occupied,
    input  logic                                   left_gt,
    input  logic signed [sli_pkg::ValueWidth-1:0]  left_value,
    input  logic signed [sli_pkg::ValueWidth-1:0]  right_value,
    output logic                                   gt,
    output logic                                   hit,
    output logic signed [sli_pkg::ValueWidth-1:0]  entry
);
    import sli_pkg::*;

    logic signed [ValueWidth-1:0] entry_reg;
    logic signed [ValueWidth-1:0] entry_next;
    logic                         boundary;

    // Compare the stored entry against the request value
    assign gt       = occupied && (entry_reg > cmd.value);
    assign boundary = !gt && left_gt;
    assign hit      = boundary && occupied && (entry_reg == cmd.value);
    assign entry    = entry_reg;

    // On an update, hold entries ahead of the boundary and shift the rest
    always_comb
    begin
        entry_next = entry_reg;
        if (cmd.update && !gt)
        begin
            if (cmd.is_insert)
            begin
                entry_next = boundary ? cmd.value : left_value;
            end
            else
            begin
                entry_next = right_value;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// ===== rtl/sli_checker.sv =====
// Port-level checker for the sorted list unit and its bind to the top level.
`include "assert_macros.svh"

module sli_checker #(
    parameter int unsigned CAPACITY = 16
) (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   req_valid,
    input logic                                   req_ready,
    input logic                                   rsp_valid,
    input logic                                   rsp_ready,
    input logic [1:0]                             status,
    input logic [sli_pkg::CountPortWidth-1:0]     entry_count
);
    import sli_pkg::*;

    localparam logic [CountPortWidth-1:0] CapCount = CountPortWidth'(CAPACITY);

    logic                        rsp_stall;
    logic                        rsp_empty;
    logic                        rsp_full;
    logic [CountPortWidth+1:0]   rsp_pl;

    // Gather the response conditions the checks look at
    assign rsp_stall = rsp_valid && !rsp_ready;
    assign rsp_empty = rsp_valid && (status == ST_EMPTY);
    assign rsp_full  = rsp_valid && (status == ST_FULL);
    assign rsp_pl    = {status, entry_count};

    // A stalled response keeps its payload
    `SLI_ASSERT_NXT(a_rsp_hold, clk, rst_n, rsp_stall, rsp_valid && $stable(rsp_pl))

    // Every accepted transaction yields a response in the next cycle
    `SLI_ASSERT_NXT(a_rsp_follows, clk, rst_n, req_valid && req_ready, rsp_valid)

    // An empty report always carries a zero count
    `SLI_ASSERT_IMP(a_empty_count, clk, rst_n, rsp_empty, entry_count == '0)

    // A full report always carries the capacity as count
    `SLI_ASSERT_IMP(a_full_count, clk, rst_n, rsp_full, entry_count == CapCount)

    // Ready only drops while a response waits
    `SLI_ASSERT_IMP(a_ready_free, clk, rst_n, !rsp_valid, req_ready)

endmodule

bind sorted_list_insert_remove_unit sli_checker #(
    .CAPACITY (CAPACITY)
) u_sli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .status      (status),
    .entry_count (entry_count)
);
